// ===== sv/ctour_pkg.sv =====
// Shared types and constants for the closed tour length block.
`default_nettype none

package ctour_pkg;

   // Fixed-point fraction bits of every segment length and of the total.
   localparam int FRAC_BITS = 8;

   localparam int COORD_W   = 8;
   // dx*dx + dy*dy for |dx|,|dy| <= 255.
   localparam int SQ_W      = 2 * COORD_W + 1;
   // Radicand of one segment root: squared distance scaled by 2^(2*FRAC_BITS).
   localparam int RAD_W     = SQ_W + 2 * FRAC_BITS;
   localparam int ROOT_W    = (RAD_W + 1) / 2;
   localparam int RADP_W    = 2 * ROOT_W;
   localparam int CNT_W     = $clog2(ROOT_W);

   localparam int TOTAL_W   = 33;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // Job queue between front and back.
   localparam int QDEPTH    = 2;
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = $clog2(QDEPTH + 1);

   typedef logic [SQ_W-1:0] sq_type;

   // One job: optional segment from the previous point, then on the last
   // point of a tour the return leg and the result.
   typedef struct packed {
      logic   has_seg;
      sq_type seg_sq;
      sq_type ret_sq;
      logic   last_pt;
   } job_type;

endpackage

`default_nettype wire

// ===== sv/ctour_front.sv =====
// Front end: tracks first and previous points and turns points into jobs.
`default_nettype none

module ctour_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                accept,
   input  wire logic signed [ctour_pkg::COORD_W-1:0] x_coord,
   input  wire logic signed [ctour_pkg::COORD_W-1:0] y_coord,
   input  wire logic                                last_point,
   output      logic                                job_push,
   output      ctour_pkg::job_type                  job
);

   function automatic logic [2*ctour_pkg::COORD_W-1:0] sq_diff(
      input logic signed [ctour_pkg::COORD_W-1:0] a,
      input logic signed [ctour_pkg::COORD_W-1:0] b
   );
      logic signed [ctour_pkg::COORD_W:0]     d;
      logic signed [2*ctour_pkg::COORD_W+1:0] p;
      d = $signed({a[ctour_pkg::COORD_W-1], a}) - $signed({b[ctour_pkg::COORD_W-1], b});
      p = d * d;
      return p[2*ctour_pkg::COORD_W-1:0];
   endfunction

   logic signed [ctour_pkg::COORD_W-1:0] first_x_ff, first_x_in;
   logic signed [ctour_pkg::COORD_W-1:0] first_y_ff, first_y_in;
   logic signed [ctour_pkg::COORD_W-1:0] prev_x_ff, prev_x_in;
   logic signed [ctour_pkg::COORD_W-1:0] prev_y_ff, prev_y_in;
   logic                                 have_first_ff, have_first_in;
   logic signed [ctour_pkg::COORD_W-1:0] home_x, home_y;

   // Return leg target: the first point, or the point itself on a one-point tour.
   assign home_x = have_first_ff ? first_x_ff : x_coord;
   assign home_y = have_first_ff ? first_y_ff : y_coord;

   always_comb begin
      job.has_seg = have_first_ff;
      job.seg_sq  = {1'b0, sq_diff(prev_x_ff, x_coord)} + {1'b0, sq_diff(prev_y_ff, y_coord)};
      job.ret_sq  = {1'b0, sq_diff(x_coord, home_x)} + {1'b0, sq_diff(y_coord, home_y)};
      job.last_pt = last_point;
   end

   // The first point of a multi-point tour produces no work.
   assign job_push = accept && (have_first_ff || last_point);

   always_comb begin
      first_x_in    = first_x_ff;
      first_y_in    = first_y_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      have_first_in = have_first_ff;
      if (accept) begin
         if (!have_first_ff) begin
            first_x_in = x_coord;
            first_y_in = y_coord;
         end
         prev_x_in     = x_coord;
         prev_y_in     = y_coord;
         have_first_in = !last_point;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_first_ff <= 1'b0;
      end else begin
         have_first_ff <= have_first_in;
      end
      first_x_ff <= first_x_in;
      first_y_ff <= first_y_in;
      prev_x_ff  <= prev_x_in;
      prev_y_ff  <= prev_y_in;
   end

endmodule

`default_nettype wire

// ===== sv/ctour_queue.sv =====
// Short job queue between the front end and the root/accumulate back end.
`default_nettype none

module ctour_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire ctour_pkg::job_type push_job,
   output      logic               full,
   input  wire logic               pop,
   output      ctour_pkg::job_type pop_job,
   output      logic               empty
);

   ctour_pkg::job_type              mem_ff [ctour_pkg::QDEPTH];
   logic [ctour_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ctour_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ctour_pkg::QCNT_W-1:0]    count_ff, count_in;

   assign full    = (count_ff == ctour_pkg::QCNT_W'(ctour_pkg::QDEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ctour_pkg::QPTR_W'(ctour_pkg::QDEPTH - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == ctour_pkg::QPTR_W'(ctour_pkg::QDEPTH - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("queue push while full");

endmodule

`default_nettype wire

// ===== sv/ctour_back.sv =====
// Back end: bit-serial square root per segment, saturating sum, result register.
`default_nettype none

module ctour_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            q_empty,
   input  wire ctour_pkg::job_type              q_job,
   output      logic                            q_pop,
   input  wire logic                            rsp_pop,
   output      logic                            rsp_empty,
   output      logic [ctour_pkg::TOTAL_W-1:0]   rsp_tour_length,
   output      logic                            rsp_saturated
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ROOT = 2'd1;
   localparam logic [1:0] S_ADD  = 2'd2;

   logic [1:0]                        state_ff, state_in;
   logic [ctour_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [ctour_pkg::RADP_W-1:0]      rad_ff, rad_in;
   logic [ctour_pkg::ROOT_W:0]        rem_ff, rem_in;
   logic [ctour_pkg::ROOT_W-1:0]      root_ff, root_in;
   logic                              ret_phase_ff, ret_phase_in;
   logic                              last_pt_ff, last_pt_in;
   ctour_pkg::sq_type                 ret_sq_ff, ret_sq_in;
   logic [ctour_pkg::TOTAL_W-1:0]     total_ff, total_in;
   logic                              ovf_ff, ovf_in;
   logic                              out_valid_ff, out_valid_in;
   logic [ctour_pkg::TOTAL_W-1:0]     out_len_ff, out_len_in;
   logic                              out_sat_ff, out_sat_in;

   logic [ctour_pkg::ROOT_W+2:0]      rem_sh, trial, rem_sub;
   logic                              take;
   logic [ctour_pkg::TOTAL_W:0]       sum;
   logic [ctour_pkg::TOTAL_W-1:0]     sum_sat;
   logic                              sum_ovf;
   logic                              out_load;

   // One root digit per cycle: two radicand bits in, one root bit out.
   assign rem_sh  = {rem_ff, rad_ff[ctour_pkg::RADP_W-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign take    = (rem_sh >= trial);
   assign rem_sub = rem_sh - trial;

   assign sum     = {1'b0, total_ff} + (ctour_pkg::TOTAL_W + 1)'(root_ff);
   assign sum_ovf = sum[ctour_pkg::TOTAL_W];
   assign sum_sat = sum_ovf ? ctour_pkg::TOTAL_MAX : sum[ctour_pkg::TOTAL_W-1:0];

   assign out_load = (state_ff == S_ADD) && ret_phase_ff && (!out_valid_ff || rsp_pop);
   assign q_pop    = (state_ff == S_IDLE) && !q_empty;

   assign rsp_empty       = !out_valid_ff;
   assign rsp_tour_length = out_len_ff;
   assign rsp_saturated   = out_sat_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      ret_phase_in = ret_phase_ff;
      last_pt_in   = last_pt_ff;
      ret_sq_in    = ret_sq_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_len_in   = out_len_ff;
      out_sat_in   = out_sat_ff;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               last_pt_in   = q_job.last_pt;
               ret_sq_in    = q_job.ret_sq;
               ret_phase_in = !q_job.has_seg;
               rad_in       = ctour_pkg::RADP_W'(q_job.has_seg ? q_job.seg_sq : q_job.ret_sq)
                              << (2 * ctour_pkg::FRAC_BITS);
               rem_in       = '0;
               root_in      = '0;
               cnt_in       = ctour_pkg::CNT_W'(ctour_pkg::ROOT_W - 1);
               state_in     = S_ROOT;
            end
         end
         S_ROOT: begin
            rad_in  = rad_ff << 2;
            rem_in  = take ? rem_sub[ctour_pkg::ROOT_W:0] : rem_sh[ctour_pkg::ROOT_W:0];
            root_in = {root_ff[ctour_pkg::ROOT_W-2:0], take};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            if (!ret_phase_ff) begin
               total_in = sum_sat;
               ovf_in   = ovf_ff || sum_ovf;
               if (last_pt_ff) begin
                  // Segment from the previous point done, now the return leg.
                  ret_phase_in = 1'b1;
                  rad_in       = ctour_pkg::RADP_W'(ret_sq_ff) << (2 * ctour_pkg::FRAC_BITS);
                  rem_in       = '0;
                  root_in      = '0;
                  cnt_in       = ctour_pkg::CNT_W'(ctour_pkg::ROOT_W - 1);
                  state_in     = S_ROOT;
               end else begin
                  state_in = S_IDLE;
               end
            end else if (out_load) begin
               out_valid_in = 1'b1;
               out_len_in   = sum_sat;
               out_sat_in   = ovf_ff || sum_ovf;
               total_in     = '0;
               ovf_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
      cnt_ff       <= cnt_in;
      rad_ff       <= rad_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      ret_phase_ff <= ret_phase_in;
      last_pt_ff   <= last_pt_in;
      ret_sq_ff    <= ret_sq_in;
      out_len_ff   <= out_len_in;
      out_sat_ff   <= out_sat_in;
   end

   a_ovf_clamped: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> total_ff == ctour_pkg::TOTAL_MAX)
      else $error("overflow flag set but total not clamped");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == S_IDLE)
      else $error("job taken while busy");

   a_no_clobber: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !out_valid_ff || rsp_pop)
      else $error("result overwritten before taken");

   a_root_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROOT) && (cnt_ff == '0) |=> state_ff == S_ADD)
      else $error("root did not finish into add");

   a_total_clear: assert property (@(posedge clock) disable iff (reset)
      out_load |=> total_ff == '0 && !ovf_ff)
      else $error("total not cleared after tour");

endmodule

`default_nettype wire

// ===== sv/closed_tour_length.sv =====
// Top level of the closed tour length block: front end, job queue, back end.
// Usage:
//   Points go in on the req_ side as a queue: an item is taken at a clock
//   edge where req_push is high and req_full is low. Each item is one point
//   (signed x/y) plus req_last_point marking the end of a tour.
//   Results come out on the rsp_ side: while rsp_empty is low the oldest
//   result sits on rsp_tour_length / rsp_saturated and leaves on rsp_pop.
//   One result per tour, after its last point; a single-point tour gives 0.
// Timing:
//   Every segment root is computed one digit per cycle, ROOT_W = 17 digits at
//   FRAC_BITS = 8, after a load step in S_IDLE and before an add step in
//   S_ADD; a last point runs the segment root and then the return leg root.
//   The first point of a tour needs no root. A one-point tour takes a single
//   root, of its zero-length return leg, once an idle block takes it.
//   A two-entry job queue lets points enter while the back end is busy.
// Reset and stall:
//   Synchronous reset empties the queue and clears the running sum, the
//   tour tracking and the result register. An unpopped result holds the
//   next finished tour in the back end; the queue fills and req_full stalls
//   the sender. Nothing is dropped.
`default_nettype none

module closed_tour_length (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output      logic                                req_full,
   input  wire logic signed [ctour_pkg::COORD_W-1:0] req_x_coord,
   input  wire logic signed [ctour_pkg::COORD_W-1:0] req_y_coord,
   input  wire logic                                req_last_point,
   output      logic                                rsp_empty,
   input  wire logic                                rsp_pop,
   output      logic [ctour_pkg::TOTAL_W-1:0]       rsp_tour_length,
   output      logic                                rsp_saturated
);

   logic               accept;
   logic               job_push;
   ctour_pkg::job_type push_job;
   ctour_pkg::job_type pop_job;
   logic               q_full;
   logic               q_empty;
   logic               q_pop;

   // Every point waits on queue space, even one that makes no job.
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   ctour_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .x_coord    (req_x_coord),
      .y_coord    (req_y_coord),
      .last_point (req_last_point),
      .job_push   (job_push),
      .job        (push_job)
   );

   ctour_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .empty    (q_empty)
   );

   ctour_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_job           (pop_job),
      .q_pop           (q_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_tour_length (rsp_tour_length),
      .rsp_saturated   (rsp_saturated)
   );

endmodule

`default_nettype wire
